// ===== hdl/assert_macros.svh =====
// assertion macros shared by the controller RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// condition that must never hold outside reset
`define ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error(msg);

`endif

// ===== hdl/plic_pkg.sv =====
// shared constants, codes and types of the interrupt controller
`timescale 1ns / 1ps
package plic_pkg;

  // parameter defaults
  localparam int NUM_SOURCES_DEF   = 32;
  localparam int NUM_CONTEXTS_DEF  = 2;
  localparam int PRIORITY_BITS_DEF = 3;

  // upper bounds that fix the command and decode field widths
  localparam int MAX_SOURCES = 64;
  localparam int MAX_ID_W    = 6;
  localparam int MAX_CTX_W   = 2;

  // word field widths
  localparam int OP_W   = 2;
  localparam int ADDR_W = 26;
  localparam int DATA_W = 32;
  localparam int LINE_W = 32;
  localparam int IRQ_W  = 2;

  // bus operation codes
  localparam logic [OP_W-1:0] OP_IDLE  = 2'd0;
  localparam logic [OP_W-1:0] OP_READ  = 2'd1;
  localparam logic [OP_W-1:0] OP_WRITE = 2'd2;

  // register map
  localparam logic [ADDR_W-1:0] PENDING_BASE = 26'h0001000;
  localparam logic [ADDR_W-1:0] ENABLE_BASE  = 26'h0002000;
  localparam logic [ADDR_W-1:0] CTX_BASE     = 26'h0200000;
  localparam logic [11:0]       THRESH_OFF   = 12'h000;
  localparam logic [11:0]       CLAIM_OFF    = 12'h004;

  // decoded register kind
  typedef enum logic [2:0] {
    DEC_NONE    = 3'd0,
    DEC_PRIO    = 3'd1,
    DEC_PENDING = 3'd2,
    DEC_ENABLE  = 3'd3,
    DEC_THRESH  = 3'd4,
    DEC_CLAIM   = 3'd5
  } dec_kind_t;

  typedef struct packed {
    dec_kind_t            kind;
    logic [MAX_ID_W-1:0]  id;
    logic [MAX_CTX_W-1:0] ctx;
    logic                 word;
  } dec_t;

  // command broadcast to every source cell
  typedef struct packed {
    logic                 set_levels;
    logic                 prio_we;
    logic                 enable_we;
    logic                 claim;
    logic                 complete;
    logic [MAX_CTX_W-1:0] ctx;
    logic [MAX_ID_W-1:0]  id;
    logic                 word;
    logic [DATA_W-1:0]    data;
  } cmd_t;

endpackage

// ===== hdl/plic_item_if.sv =====
// input channel: source levels and one bus access per word
`timescale 1ns / 1ps
interface plic_item_if;
  logic                          valid;
  logic                          ready;
  logic [plic_pkg::OP_W-1:0]     op;
  logic [plic_pkg::ADDR_W-1:0]   addr;
  logic [plic_pkg::DATA_W-1:0]   wdata;
  logic [plic_pkg::LINE_W-1:0]   source_levels;

  modport source (output valid, op, addr, wdata, source_levels, input ready);
  modport sink (input valid, op, addr, wdata, source_levels, output ready);
endinterface

// ===== hdl/plic_result_if.sv =====
// output channel: read data and per-context interrupt requests
`timescale 1ns / 1ps
interface plic_result_if;
  logic                         valid;
  logic                         ready;
  logic [plic_pkg::DATA_W-1:0]  rdata;
  logic [plic_pkg::IRQ_W-1:0]   irq_request;

  modport source (output valid, rdata, irq_request, input ready);
  modport sink (input valid, rdata, irq_request, output ready);
endinterface

// ===== hdl/plic_decode.sv =====
// bus address decoder for the controller register map
`timescale 1ns / 1ps
module plic_decode #(
  parameter int NUM_SOURCES  = plic_pkg::NUM_SOURCES_DEF,
  parameter int NUM_CONTEXTS = plic_pkg::NUM_CONTEXTS_DEF
) (
  input  logic [plic_pkg::ADDR_W-1:0] addr,
  output plic_pkg::dec_t              dec
);

  localparam int ENABLE_WORDS = (NUM_SOURCES + 31) / 32;

  logic [plic_pkg::ADDR_W-1:0] a;
  logic [9:0]                  id_wide;
  logic [4:0]                  pend_word;
  logic [plic_pkg::ADDR_W-1:0] en_off;
  logic [18:0]                 en_ctx;
  logic [4:0]                  en_word;
  logic [plic_pkg::ADDR_W-1:0] ctx_off;
  logic [13:0]                 ctx_sel;
  logic [11:0]                 ctx_reg;

  // region offsets
  assign a         = {addr[plic_pkg::ADDR_W-1:2], 2'b00};
  assign id_wide   = a[11:2];
  assign pend_word = a[6:2];
  assign en_off    = a - plic_pkg::ENABLE_BASE;
  assign en_ctx    = en_off[25:7];
  assign en_word   = en_off[6:2];
  assign ctx_off   = a - plic_pkg::CTX_BASE;
  assign ctx_sel   = ctx_off[25:12];
  assign ctx_reg   = ctx_off[11:0];

  // region select
  always_comb begin
    dec.kind = plic_pkg::DEC_NONE;
    dec.id   = id_wide[plic_pkg::MAX_ID_W-1:0];
    dec.ctx  = '0;
    dec.word = 1'b0;
    if (a < plic_pkg::PENDING_BASE) begin
      if (id_wide != '0 && id_wide < 10'(NUM_SOURCES)) begin
        dec.kind = plic_pkg::DEC_PRIO;
      end
    end else if (a < plic_pkg::ENABLE_BASE) begin
      dec.word = pend_word[0];
      if (a[11:7] == '0 && pend_word < 5'(ENABLE_WORDS)) begin
        dec.kind = plic_pkg::DEC_PENDING;
      end
    end else if (a < plic_pkg::CTX_BASE) begin
      dec.word = en_word[0];
      dec.ctx  = en_ctx[plic_pkg::MAX_CTX_W-1:0];
      if (en_ctx < 19'(NUM_CONTEXTS) && en_word < 5'(ENABLE_WORDS)) begin
        dec.kind = plic_pkg::DEC_ENABLE;
      end
    end else begin
      dec.ctx = ctx_sel[plic_pkg::MAX_CTX_W-1:0];
      if (ctx_sel < 14'(NUM_CONTEXTS)) begin
        if (ctx_reg == plic_pkg::THRESH_OFF) begin
          dec.kind = plic_pkg::DEC_THRESH;
        end else if (ctx_reg == plic_pkg::CLAIM_OFF) begin
          dec.kind = plic_pkg::DEC_CLAIM;
        end
      end
    end
  end

endmodule

// ===== hdl/plic_cell.sv =====
// one interrupt source: its state and one stage of the claim arbitration chain
`timescale 1ns / 1ps
module plic_cell #(
  parameter int ID            = 1,
  parameter int NUM_CONTEXTS  = plic_pkg::NUM_CONTEXTS_DEF,
  parameter int PRIORITY_BITS = plic_pkg::PRIORITY_BITS_DEF,
  parameter int SRC_W         = 5
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  plic_pkg::cmd_t                             cmd,
  input  logic [NUM_CONTEXTS-1:0][PRIORITY_BITS-1:0] best_prio_in,
  input  logic [NUM_CONTEXTS-1:0][SRC_W-1:0]         best_id_in,
  output logic [NUM_CONTEXTS-1:0][PRIORITY_BITS-1:0] best_prio_out,
  output logic [NUM_CONTEXTS-1:0][SRC_W-1:0]         best_id_out,
  output logic [PRIORITY_BITS-1:0]                   prio,
  output logic                                       pending,
  output logic                                       in_flight,
  output logic [NUM_CONTEXTS-1:0]                    enable
);

  localparam int CTX_W    = (NUM_CONTEXTS > 1) ? $clog2(NUM_CONTEXTS) : 1;
  localparam int LINE_BIT = ID % 32;
  localparam bit HAS_LINE = (ID < plic_pkg::LINE_W);
  localparam logic WORD   = 1'(ID / 32);
  localparam logic [plic_pkg::MAX_ID_W-1:0] MY_ID = plic_pkg::MAX_ID_W'(ID);

  logic level;
  logic hit;

  assign level = HAS_LINE & cmd.data[LINE_BIT];
  assign hit   = (cmd.id == MY_ID);

  // source state updates
  always_ff @(posedge clk) begin
    if (rst) begin
      prio      <= '0;
      pending   <= 1'b0;
      in_flight <= 1'b0;
      enable    <= '0;
    end else begin
      if (cmd.set_levels && level && !in_flight) begin
        pending <= 1'b1;
      end
      if (cmd.prio_we && hit) begin
        prio <= cmd.data[PRIORITY_BITS-1:0];
      end
      if (cmd.enable_we && cmd.word == WORD) begin
        enable[cmd.ctx[CTX_W-1:0]] <= cmd.data[LINE_BIT];
      end
      if (cmd.claim && hit) begin
        pending   <= 1'b0;
        in_flight <= 1'b1;
      end
      if (cmd.complete && hit && enable[cmd.ctx[CTX_W-1:0]]) begin
        in_flight <= 1'b0;
      end
    end
  end

  // arbitration stage: take over only on a strictly higher priority
  always_ff @(posedge clk) begin
    for (int c = 0; c < NUM_CONTEXTS; c++) begin
      if (pending && enable[c] && prio > best_prio_in[c]) begin
        best_prio_out[c] <= prio;
        best_id_out[c]   <= SRC_W'(ID);
      end else begin
        best_prio_out[c] <= best_prio_in[c];
        best_id_out[c]   <= best_id_in[c];
      end
    end
  end

endmodule

// ===== hdl/platform_interrupt_controller.sv =====
// top level of the platform interrupt controller
//
//   port    | dir | words carried
//   --------+-----+----------------------------------------------
//   item    | in  | op, addr, wdata, source_levels
//   result  | out | rdata, irq_request (one per item word)
//
// An item is sequenced through the source cell chain, which carries a winner
// from the first cell to the last: once before a claim, for a claim read only,
// and once after the access to form irq_request.
// Reset is synchronous and clears all priorities, enables, thresholds and
// pending and in-flight marks at once; no clearing pass follows.
// The result register frees the input side: a new item is taken while a
// result waits; the block holds its next result until the register is free.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module platform_interrupt_controller #(
  parameter int NUM_SOURCES   = plic_pkg::NUM_SOURCES_DEF,
  parameter int NUM_CONTEXTS  = plic_pkg::NUM_CONTEXTS_DEF,
  parameter int PRIORITY_BITS = plic_pkg::PRIORITY_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  plic_item_if.sink      item,
  plic_result_if.source  result
);

  localparam int SRC_W      = $clog2(NUM_SOURCES);
  localparam int CTX_W      = (NUM_CONTEXTS > 1) ? $clog2(NUM_CONTEXTS) : 1;
  localparam int DEPTH      = NUM_SOURCES - 1;
  localparam int CNT_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int IRQ_CTX    = (NUM_CONTEXTS < 2) ? NUM_CONTEXTS : 2;
  localparam logic [CNT_W-1:0] SCAN_LAST = CNT_W'(DEPTH - 1);

  typedef enum logic [4:0] {
    S_IDLE       = 5'b00001,
    S_SCAN_CLAIM = 5'b00010,
    S_ACCESS     = 5'b00100,
    S_SCAN_REQ   = 5'b01000,
    S_DONE       = 5'b10000
  } state_t;

  state_t                         state;
  state_t                         state_next;
  logic [CNT_W-1:0]               scan_cnt;
  logic [CNT_W-1:0]               scan_cnt_next;
  logic [plic_pkg::OP_W-1:0]      op_q;
  logic [plic_pkg::DATA_W-1:0]    wdata_q;
  plic_pkg::dec_t                 dec_in;
  plic_pkg::dec_t                 dec_q;
  plic_pkg::cmd_t                 cmd;
  logic [plic_pkg::DATA_W-1:0]    rdata_next;
  logic [plic_pkg::DATA_W-1:0]    rdata_q;
  logic                           thresh_we;
  logic [NUM_CONTEXTS-1:0][PRIORITY_BITS-1:0] thresh;
  logic                           accept;
  logic                           load_out;
  logic                           out_valid;
  logic [plic_pkg::DATA_W-1:0]    out_rdata;
  logic [plic_pkg::IRQ_W-1:0]     out_irq;
  logic [plic_pkg::IRQ_W-1:0]     irq_next;

  // per-source views of the cell row
  logic                           pend_bit   [plic_pkg::MAX_SOURCES];
  logic                           flight_bit [plic_pkg::MAX_SOURCES];
  logic [PRIORITY_BITS-1:0]       prio_arr   [plic_pkg::MAX_SOURCES];
  logic [NUM_CONTEXTS-1:0]        en_arr     [plic_pkg::MAX_SOURCES];
  logic [plic_pkg::MAX_SOURCES-1:0]                    pend_all;
  logic [plic_pkg::MAX_SOURCES-1:0]                    flight_all;
  logic [NUM_CONTEXTS-1:0][plic_pkg::MAX_SOURCES-1:0]  en_all;

  // arbitration chain links, index 0 is the head
  logic [NUM_CONTEXTS-1:0][PRIORITY_BITS-1:0] chain_prio [NUM_SOURCES];
  logic [NUM_CONTEXTS-1:0][SRC_W-1:0]         chain_id   [NUM_SOURCES];

  logic [SRC_W-1:0]               claim_id;

  // address decode of the incoming word
  plic_decode #(
    .NUM_SOURCES  (NUM_SOURCES),
    .NUM_CONTEXTS (NUM_CONTEXTS)
  ) u_decode (
    .addr (item.addr),
    .dec  (dec_in)
  );

  // row of source cells; source zero and unused slots read as zero
  for (genvar i = 0; i < plic_pkg::MAX_SOURCES; i++) begin : g_src
    if (i > 0 && i < NUM_SOURCES) begin : g_cell
      plic_cell #(
        .ID            (i),
        .NUM_CONTEXTS  (NUM_CONTEXTS),
        .PRIORITY_BITS (PRIORITY_BITS),
        .SRC_W         (SRC_W)
      ) u_cell (
        .clk           (clk),
        .rst           (rst),
        .cmd           (cmd),
        .best_prio_in  (chain_prio[i-1]),
        .best_id_in    (chain_id[i-1]),
        .best_prio_out (chain_prio[i]),
        .best_id_out   (chain_id[i]),
        .prio          (prio_arr[i]),
        .pending       (pend_bit[i]),
        .in_flight     (flight_bit[i]),
        .enable        (en_arr[i])
      );
    end else begin : g_none
      assign prio_arr[i]   = '0;
      assign pend_bit[i]   = 1'b0;
      assign flight_bit[i] = 1'b0;
      assign en_arr[i]     = '0;
    end
  end

  // chain head: thresholds with no winner
  assign chain_prio[0] = thresh;
  assign chain_id[0]   = '0;

  // gather per-source bits into words
  always_comb begin
    for (int i = 0; i < plic_pkg::MAX_SOURCES; i++) begin
      pend_all[i]   = pend_bit[i];
      flight_all[i] = flight_bit[i];
      for (int c = 0; c < NUM_CONTEXTS; c++) begin
        en_all[c][i] = en_arr[i][c];
      end
    end
  end

  assign accept      = item.valid && item.ready;
  assign item.ready  = (state == S_IDLE);
  assign claim_id    = chain_id[NUM_SOURCES-1][dec_q.ctx[CTX_W-1:0]];
  assign load_out    = (state == S_DONE) && (!out_valid || result.ready);

  // sequencer
  always_comb begin
    state_next    = state;
    scan_cnt_next = scan_cnt;
    case (state)
      S_IDLE: begin
        scan_cnt_next = '0;
        if (accept) begin
          if (item.op == plic_pkg::OP_READ && dec_in.kind == plic_pkg::DEC_CLAIM) begin
            state_next = S_SCAN_CLAIM;
          end else begin
            state_next = S_ACCESS;
          end
        end
      end
      S_SCAN_CLAIM: begin
        scan_cnt_next = scan_cnt + 1'b1;
        if (scan_cnt == SCAN_LAST) begin
          state_next = S_ACCESS;
        end
      end
      S_ACCESS: begin
        scan_cnt_next = '0;
        state_next    = S_SCAN_REQ;
      end
      S_SCAN_REQ: begin
        scan_cnt_next = scan_cnt + 1'b1;
        if (scan_cnt == SCAN_LAST) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (load_out) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // cell commands and read data
  always_comb begin
    cmd        = '0;
    rdata_next = '0;
    thresh_we  = 1'b0;
    if (state == S_IDLE) begin
      cmd.set_levels = accept;
      cmd.data       = item.source_levels;
    end else if (state == S_ACCESS) begin
      cmd.data = wdata_q;
      cmd.ctx  = dec_q.ctx;
      cmd.id   = dec_q.id;
      cmd.word = dec_q.word;
      case (dec_q.kind)
        plic_pkg::DEC_PRIO: begin
          if (op_q == plic_pkg::OP_READ) begin
            rdata_next = plic_pkg::DATA_W'(prio_arr[dec_q.id]);
          end
          cmd.prio_we = (op_q == plic_pkg::OP_WRITE);
        end
        plic_pkg::DEC_PENDING: begin
          if (op_q == plic_pkg::OP_READ) begin
            rdata_next = dec_q.word ? pend_all[63:32] : pend_all[31:0];
          end
        end
        plic_pkg::DEC_ENABLE: begin
          if (op_q == plic_pkg::OP_READ) begin
            rdata_next = dec_q.word ? en_all[dec_q.ctx[CTX_W-1:0]][63:32]
                                    : en_all[dec_q.ctx[CTX_W-1:0]][31:0];
          end
          cmd.enable_we = (op_q == plic_pkg::OP_WRITE);
        end
        plic_pkg::DEC_THRESH: begin
          if (op_q == plic_pkg::OP_READ) begin
            rdata_next = plic_pkg::DATA_W'(thresh[dec_q.ctx[CTX_W-1:0]]);
          end
          thresh_we = (op_q == plic_pkg::OP_WRITE);
        end
        plic_pkg::DEC_CLAIM: begin
          if (op_q == plic_pkg::OP_READ) begin
            rdata_next = plic_pkg::DATA_W'(claim_id);
            cmd.claim  = (claim_id != '0);
            cmd.id     = plic_pkg::MAX_ID_W'(claim_id);
          end else if (op_q == plic_pkg::OP_WRITE) begin
            cmd.complete = (wdata_q != '0) && (wdata_q < plic_pkg::DATA_W'(NUM_SOURCES));
            cmd.id       = wdata_q[plic_pkg::MAX_ID_W-1:0];
          end
        end
        default: begin
          rdata_next = '0;
        end
      endcase
    end
  end

  // interrupt request per context from the settled chain
  always_comb begin
    irq_next = '0;
    for (int c = 0; c < IRQ_CTX; c++) begin
      irq_next[c] = (chain_id[NUM_SOURCES-1][c] != '0);
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      scan_cnt  <= '0;
      thresh    <= '0;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      scan_cnt <= scan_cnt_next;
      if (thresh_we) begin
        thresh[dec_q.ctx[CTX_W-1:0]] <= wdata_q[PRIORITY_BITS-1:0];
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // item and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q    <= item.op;
      wdata_q <= item.wdata;
      dec_q   <= dec_in;
    end
    if (state == S_ACCESS) begin
      rdata_q <= rdata_next;
    end
    if (load_out) begin
      out_rdata <= rdata_q;
      out_irq   <= irq_next;
    end
  end

  assign result.valid       = out_valid;
  assign result.rdata       = out_rdata;
  assign result.irq_request = out_irq;

  // checks
  `ASSERT_NEVER(a_pend_and_flight, |(pend_all & flight_all), "source both pending and in flight")
  `ASSERT_RST(a_claim_marks, cmd.claim |=> flight_all[$past(cmd.id)], "claimed source not in flight")
  `ASSERT_RST(a_claim_beats, cmd.claim |-> prio_arr[cmd.id] > thresh[dec_q.ctx[CTX_W-1:0]], "claim winner below threshold")

endmodule

// ===== test/tb.sv =====
// self-checking testbench for the platform interrupt controller
`timescale 1ns / 1ps
module tb;
  import plic_pkg::*;

  // controller configuration under test (block defaults)
  localparam int N_SRC  = NUM_SOURCES_DEF;
  localparam int N_CTX  = NUM_CONTEXTS_DEF;
  localparam int PRIO_W = PRIORITY_BITS_DEF;
  localparam logic [31:0] SRC_MASK = 32'hFFFF_FFFE;
  localparam int ENABLE_STRIDE = 'h80;
  localparam int CTX_STRIDE    = 'h1000;
  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
  localparam int RANDOM_WORDS = 1200;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 100;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] wdata;
    logic [LINE_W-1:0] levels;
  } bus_word_t;

  typedef struct packed {
    logic [DATA_W-1:0] rdata;
    logic [IRQ_W-1:0]  irq;
  } plic_result_t;

  logic clk = 1'b0;
  logic rst;

  plic_item_if   item_ch();
  plic_result_if result_ch();

  platform_interrupt_controller u_dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow copy of the controller state
  logic [PRIO_W-1:0] ctl_prio [N_SRC];
  logic [31:0]       ctl_pending;
  logic [31:0]       ctl_in_flight;
  logic [31:0]       ctl_enable [N_CTX];
  logic [PRIO_W-1:0] ctl_thresh [N_CTX];

  bus_word_t    word_q [$];
  plic_result_t result_q [$];
  bus_word_t    cur_word;
  int           error_count = 0;
  int           cycle_count = 0;
  int           send_gap = 0;
  int           send_calm = 0;
  int           recv_stall = 0;
  int           recv_calm = 0;

  // winning source for a context, 0 when nothing beats the threshold
  function automatic logic [31:0] pick_winner(int ctx);
    logic [31:0]       cand;
    logic [PRIO_W-1:0] best_prio;
    logic [31:0]       best;
    cand = ctl_pending & ctl_enable[ctx] & SRC_MASK;
    best_prio = ctl_thresh[ctx];
    best = '0;
    for (int id = 1; id < N_SRC; id++) begin
      if (cand[id] && ctl_prio[id] > best_prio) begin
        best = id;
        best_prio = ctl_prio[id];
      end
    end
    return best;
  endfunction

  // register file access, returns the read data
  function automatic logic [31:0] access_regs(bit wr, logic [ADDR_W-1:0] a,
                                              logic [31:0] wd);
    logic [31:0] rd;
    logic [31:0] off;
    logic [31:0] win;
    int unsigned ctx;
    int unsigned w;
    int unsigned id;
    int unsigned r;
    rd = '0;
    if (a < PENDING_BASE) begin
      id = a >> 2;
      if (id != 0 && id < N_SRC) begin
        if (wr) ctl_prio[id] = wd[PRIO_W-1:0];
        else rd = ctl_prio[id];
      end
    end else if (a < ENABLE_BASE) begin
      w = (a - PENDING_BASE) >> 2;
      if (!wr && w == 0) rd = ctl_pending;
    end else if (a < CTX_BASE) begin
      off = a - ENABLE_BASE;
      ctx = off / ENABLE_STRIDE;
      w = (off % ENABLE_STRIDE) >> 2;
      if (ctx < N_CTX && w == 0) begin
        if (wr) ctl_enable[ctx] = wd & SRC_MASK;
        else rd = ctl_enable[ctx];
      end
    end else begin
      off = a - CTX_BASE;
      ctx = off / CTX_STRIDE;
      r = off % CTX_STRIDE;
      if (ctx < N_CTX) begin
        if (r == THRESH_OFF) begin
          if (wr) ctl_thresh[ctx] = wd[PRIO_W-1:0];
          else rd = ctl_thresh[ctx];
        end else if (r == CLAIM_OFF) begin
          if (wr) begin
            // completion only counts for a real source enabled in this context
            if (wd != 0 && wd < N_SRC && ctl_enable[ctx][wd[4:0]])
              ctl_in_flight[wd[4:0]] = 1'b0;
          end else begin
            win = pick_winner(ctx);
            if (win != 0) begin
              ctl_pending[win[4:0]] = 1'b0;
              ctl_in_flight[win[4:0]] = 1'b1;
            end
            rd = win;
          end
        end
      end
    end
    return rd;
  endfunction

  // levels first, then the bus access, then the request lines
  function automatic plic_result_t predict_word(bus_word_t bw);
    plic_result_t res;
    logic [ADDR_W-1:0] a;
    a = {bw.addr[ADDR_W-1:2], 2'b00};
    res = '0;
    ctl_pending |= bw.levels & ~ctl_in_flight & SRC_MASK;
    if (bw.op == OP_READ) res.rdata = access_regs(1'b0, a, bw.wdata);
    else if (bw.op == OP_WRITE) void'(access_regs(1'b1, a, bw.wdata));
    for (int c = 0; c < N_CTX && c < IRQ_W; c++)
      res.irq[c] = (pick_winner(c) != 0);
    return res;
  endfunction

  // idle length: mostly short, a few long, with calm stretches of none
  function automatic int pick_gap(inout int calm_left);
    int roll;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 2) begin
      calm_left = $urandom_range(30, 120);
      return 0;
    end
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [ADDR_W-1:0] prio_addr(int id);
    return ADDR_W'(id * 4);
  endfunction

  function automatic logic [ADDR_W-1:0] enable_addr(int ctx, int w);
    return ENABLE_BASE + ADDR_W'(ctx * ENABLE_STRIDE + 4 * w);
  endfunction

  function automatic logic [ADDR_W-1:0] ctx_addr(int ctx, logic [11:0] off);
    return CTX_BASE + ADDR_W'(ctx * CTX_STRIDE) + ADDR_W'(off);
  endfunction

  task automatic add_word(logic [OP_W-1:0] op, logic [ADDR_W-1:0] addr,
                          logic [DATA_W-1:0] wdata, logic [LINE_W-1:0] levels);
    bus_word_t bw;
    bw.op = op;
    bw.addr = addr;
    bw.wdata = wdata;
    bw.levels = levels;
    word_q.push_back(bw);
  endtask

  // driver: predicts each accepted word, then presents the next one
  always @(posedge clk) begin
    if (rst) begin
      item_ch.valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (item_ch.valid && item_ch.ready) begin
        result_q.push_back(predict_word(cur_word));
        send_gap = pick_gap(send_calm);
      end
      if (!(item_ch.valid && !item_ch.ready)) begin
        if (send_gap == 0 && word_q.size() > 0) begin
          cur_word = word_q.pop_front();
          item_ch.valid <= 1'b1;
          item_ch.op <= cur_word.op;
          item_ch.addr <= cur_word.addr;
          item_ch.wdata <= cur_word.wdata;
          item_ch.source_levels <= cur_word.levels;
        end else begin
          if (send_gap > 0) send_gap--;
          item_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each result word and drives the stalls
  always @(posedge clk) begin
    plic_result_t exp_res;
    if (rst) begin
      result_ch.ready <= 1'b0;
      recv_stall = 0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        if (result_q.size() == 0) begin
          $error("result word with no item waiting: rdata %h irq_request %b",
                 result_ch.rdata, result_ch.irq_request);
          error_count++;
        end else begin
          exp_res = result_q.pop_front();
          if (result_ch.rdata !== exp_res.rdata) begin
            $error("rdata: expected %h, got %h", exp_res.rdata, result_ch.rdata);
            error_count++;
          end
          if (result_ch.irq_request !== exp_res.irq) begin
            $error("irq_request: expected %b, got %b", exp_res.irq,
                   result_ch.irq_request);
            error_count++;
          end
        end
      end
      if (recv_stall == 0 &&
          ((result_ch.valid && result_ch.ready) || $urandom_range(0, 15) == 0))
        recv_stall = pick_gap(recv_calm);
      if (recv_stall > 0) begin
        recv_stall--;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int roll;
    int ctx;
    bus_word_t bw;
    rst = 1'b1;
    item_ch.valid = 1'b0;
    item_ch.op = OP_IDLE;
    item_ch.addr = '0;
    item_ch.wdata = '0;
    item_ch.source_levels = '0;
    result_ch.ready = 1'b0;
    for (int i = 0; i < N_SRC; i++) ctl_prio[i] = '0;
    for (int i = 0; i < N_CTX; i++) begin
      ctl_enable[i] = '0;
      ctl_thresh[i] = '0;
    end
    ctl_pending = '0;
    ctl_in_flight = '0;

    // directed words: map corners and the special cases
    add_word(OP_WRITE, prio_addr(1), 32'hFFFF_FFFF, '0);      // wide priority
    add_word(OP_WRITE, prio_addr(2), 32'd7, '0);
    add_word(OP_WRITE, prio_addr(31), 32'd5, '0);
    add_word(OP_WRITE, prio_addr(0), 32'd7, '0);              // source zero
    add_word(OP_READ, prio_addr(0), '0, '0);
    add_word(OP_READ, prio_addr(31) | 26'd3, '0, '0);         // byte offset ignored
    add_word(OP_WRITE, prio_addr(N_SRC), 32'd3, '0);          // no such source
    add_word(OP_WRITE, enable_addr(0, 0), 32'hFFFF_FFFF, '0);
    add_word(OP_WRITE, enable_addr(1, 0), 32'h8000_000A, '0);
    add_word(OP_WRITE, enable_addr(1, 1), 32'hFFFF_FFFF, '0); // second word absent
    add_word(OP_READ, enable_addr(1, 1), '0, '0);
    add_word(OP_WRITE, ctx_addr(0, THRESH_OFF), 32'hFFFF_FFF9, '0);
    add_word(OP_IDLE, '0, '0, 32'hFFFF_FFFF);                 // every line high
    add_word(OP_READ, PENDING_BASE, '0, '0);
    add_word(OP_WRITE, PENDING_BASE, '0, '0);                 // pending is read only
    add_word(OP_READ, ctx_addr(0, CLAIM_OFF), '0, '0);        // tie to lowest id
    add_word(OP_READ, ctx_addr(0, CLAIM_OFF), '0, 32'h2);     // level while in flight
    add_word(OP_READ, ctx_addr(1, CLAIM_OFF), '0, '0);
    add_word(OP_READ, ctx_addr(1, CLAIM_OFF), '0, '0);        // empty claim
    add_word(OP_WRITE, ctx_addr(1, CLAIM_OFF), 32'd2, '0);    // not enabled there
    add_word(OP_WRITE, ctx_addr(0, CLAIM_OFF), 32'd0, '0);
    add_word(OP_WRITE, ctx_addr(0, CLAIM_OFF), 32'd40, '0);
    add_word(OP_WRITE, ctx_addr(0, CLAIM_OFF), 32'd1, 32'h2);
    add_word(OP_WRITE, ctx_addr(2, THRESH_OFF), 32'd3, '0);   // missing context
    add_word(OP_READ, ctx_addr(3, CLAIM_OFF), '0, '0);
    add_word(OP_READ, ctx_addr(0, THRESH_OFF), '0, '0);
    add_word(OP_READ, ctx_addr(0, 12'h008), '0, '0);          // unmapped
    add_word(OP_SPARE, '1, 32'hFFFF_FFFF, 32'h1);
    add_word(OP_WRITE, '1, 32'hFFFF_FFFF, '0);

    // random words, mostly well-formed register traffic
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      bw.wdata = $urandom;
      ctx = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 3) : $urandom_range(0, 1);
      roll = $urandom_range(0, 99);
      if (roll < 12) begin
        bw.op = OP_WRITE;
        bw.addr = prio_addr($urandom_range(0, 33));
        if ($urandom_range(0, 9) < 7) bw.wdata = $urandom_range(0, 7);
      end else if (roll < 18) begin
        bw.op = OP_READ;
        bw.addr = prio_addr($urandom_range(0, 33));
      end else if (roll < 26) begin
        bw.op = OP_WRITE;
        bw.addr = enable_addr(ctx, ($urandom_range(0, 9) == 0) ? $urandom_range(1, 31) : 0);
      end else if (roll < 30) begin
        bw.op = OP_READ;
        bw.addr = enable_addr(ctx, ($urandom_range(0, 9) == 0) ? $urandom_range(1, 31) : 0);
      end else if (roll < 33) begin
        bw.op = $urandom_range(0, 1) ? OP_READ : OP_WRITE;
        bw.addr = PENDING_BASE + ADDR_W'(4 * $urandom_range(0, 2));
      end else if (roll < 38) begin
        bw.op = OP_WRITE;
        bw.addr = ctx_addr(ctx, THRESH_OFF);
        if ($urandom_range(0, 9) < 8) bw.wdata = $urandom_range(0, 3);
      end else if (roll < 41) begin
        bw.op = OP_READ;
        bw.addr = ctx_addr(ctx, THRESH_OFF);
      end else if (roll < 63) begin
        bw.op = OP_READ;
        bw.addr = ctx_addr(ctx, CLAIM_OFF);
      end else if (roll < 79) begin
        bw.op = OP_WRITE;
        bw.addr = ctx_addr(ctx, CLAIM_OFF);
        if ($urandom_range(0, 19) < 17) bw.wdata = $urandom_range(1, N_SRC - 1);
        else if ($urandom_range(0, 1)) bw.wdata = '0;
      end else if (roll < 87) begin
        bw.op = $urandom_range(0, 3) == 0 ? OP_SPARE : OP_IDLE;
        bw.addr = $urandom;
      end else if (roll < 95) begin
        bw.op = $urandom_range(0, 3);
        bw.addr = $urandom;
      end else begin
        bw.op = $urandom_range(0, 1) ? OP_READ : OP_WRITE;
        bw.addr = ctx_addr(ctx, 12'(4 * $urandom_range(0, 15)));
      end
      // stray byte-offset bits on every kind
      bw.addr[1:0] = $urandom_range(0, 3);
      roll = $urandom_range(0, 99);
      if (roll < 50) bw.levels = '0;
      else if (roll < 85) bw.levels = (32'h1 << $urandom_range(0, 31)) |
                                      (32'h1 << $urandom_range(0, 31));
      else bw.levels = $urandom;
      word_q.push_back(bw);
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    wait (word_q.size() == 0 && !item_ch.valid);
    wait (result_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
